// ===== rtl/gbp_pkg.sv =====
// gbp_pkg: shared types and constants for the gshare branch predictor.
// Holds the beat payload structs, counter constants and register indexes.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package gbp_pkg;

    // Fixed field widths.
    localparam int PC_WIDTH  = 24;
    localparam int TOTAL_W   = 32;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_BITS = 2'd1;

    // Register values after reset.
    localparam logic [CFG_W-1:0] RST_INDEX_BITS   = 4'd9;
    localparam logic [CFG_W-1:0] RST_HISTORY_BITS = 4'd3;

    // Three-bit saturating counters.
    localparam int              CNT_W    = 3;
    localparam logic [CNT_W-1:0] CNT_INIT = 3'd4;
    localparam logic [CNT_W-1:0] CNT_MAX  = 3'd7;
    localparam logic [CNT_W-1:0] CNT_MIN  = 3'd0;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic [PC_WIDTH-1:0] branch_pc;
        logic                taken;
    } branch_t;

    typedef struct packed {
        logic               predicted_taken;
        logic               mispredicted;
        logic [TOTAL_W-1:0] prediction_total;
        logic [TOTAL_W-1:0] mispredict_total;
    } result_t;

endpackage

// ===== rtl/gshare_branch_predictor.sv =====
// gshare_branch_predictor: top level of the gshare predictor with its
// configuration registers, lookup stage, totals and result register.
// Depends on gbp_pkg, gbp_index_hash and gbp_counter_table.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// branch    in         branch_valid/ready        branch_t: branch_pc, taken
// result    out        result_valid/ready        result_t: prediction and totals
// cfg       in         cfg_valid/ready           cfg_index, cfg_data (register write)
//
// Each branch beat yields exactly one result beat. A new beat can be taken every
// cycle unless the counter sweep runs or a stalled result holds the lookup stage.
// The index is hashed and the read issued on acceptance; the counter is updated
// and the result registered when the lookup stage advances. After reset the
// counter memory is swept to weakly taken, one entry per cycle over all
// 2^MAX_INDEX_BITS entries (4096 by default); branch_ready stays low then.
// When the result side stalls, the lookup stage holds and backpressure reaches
// branch_ready in the same cycle. Configuration writes are always taken.

module gshare_branch_predictor
    import gbp_pkg::*;
#(
    parameter int MAX_INDEX_BITS = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 branch_valid,
    output logic                 branch_ready,
    input  branch_t              branch,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int IDX_W = MAX_INDEX_BITS;

    // Configuration registers, stored raw and clamped where they are used.
    logic [CFG_W-1:0] index_bits_reg;
    logic [CFG_W-1:0] history_bits_reg;

    // Global history and the hashed index of the arriving branch.
    logic [IDX_W-1:0] history_reg;
    logic [IDX_W-1:0] history_next;
    logic [IDX_W-1:0] lookup_idx;

    // Lookup stage: the branch whose counter read is in flight.
    logic             s1_valid_reg;
    logic             s1_taken_reg;
    logic [IDX_W-1:0] s1_idx_reg;

    // Running totals and the result register.
    logic [TOTAL_W-1:0] branch_count_reg;
    logic [TOTAL_W-1:0] branch_count_next;
    logic [TOTAL_W-1:0] miss_count_reg;
    logic [TOTAL_W-1:0] miss_count_next;
    logic               result_valid_reg;
    result_t            result_reg;

    logic             table_busy;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] cnt_next;
    logic             pred;
    logic             miss;
    logic             accept;
    logic             s1_adv;

    assign cfg_ready = 1'b1;

    // The lookup stage moves on whenever the result register is free or emptying.
    assign s1_adv       = s1_valid_reg && (!result_valid_reg || result_ready);
    assign branch_ready = !table_busy && (!s1_valid_reg || s1_adv);
    assign accept       = branch_valid && branch_ready;

    gbp_index_hash #(
        .IDX_W (IDX_W)
    ) u_hash (
        .pc           (branch.branch_pc),
        .taken        (branch.taken),
        .history      (history_reg),
        .index_bits   (index_bits_reg),
        .history_bits (history_bits_reg),
        .index        (lookup_idx),
        .history_next (history_next)
    );

    gbp_counter_table #(
        .IDX_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (lookup_idx),
        .wr_en   (s1_adv),
        .wr_addr (s1_idx_reg),
        .wr_data (cnt_next),
        .rd_data (cnt),
        .busy    (table_busy)
    );

    // The top counter bit is the prediction; the counter then steps toward
    // the outcome and saturates at both ends.
    always_comb
    begin
        pred = cnt[CNT_W-1];
        miss = pred ^ s1_taken_reg;
        if (s1_taken_reg && (cnt != CNT_MAX))
        begin
            cnt_next = cnt + CNT_W'(1);
        end
        else if (!s1_taken_reg && (cnt != CNT_MIN))
        begin
            cnt_next = cnt - CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt;
        end

        branch_count_next = (branch_count_reg == TOTAL_MAX) ? branch_count_reg
                                                             : branch_count_reg + TOTAL_W'(1);
        if (miss && (miss_count_reg != TOTAL_MAX))
        begin
            miss_count_next = miss_count_reg + TOTAL_W'(1);
        end
        else
        begin
            miss_count_next = miss_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg   <= RST_INDEX_BITS;
            history_bits_reg <= RST_HISTORY_BITS;
            history_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            branch_count_reg <= '0;
            miss_count_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // Writes to an index beyond the register list are dropped.
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_INDEX_BITS:   index_bits_reg   <= cfg_data;
                    CFG_HISTORY_BITS: history_bits_reg <= cfg_data;
                    default:          ;
                endcase
            end

            // History depends only on the outcome, so it advances on acceptance.
            if (accept)
            begin
                history_reg <= history_next;
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                branch_count_reg <= branch_count_next;
                miss_count_reg   <= miss_count_next;
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_taken_reg <= branch.taken;
            s1_idx_reg   <= lookup_idx;
        end
        if (s1_adv)
        begin
            result_reg.predicted_taken  <= pred;
            result_reg.mispredicted     <= miss;
            result_reg.prediction_total <= branch_count_next;
            result_reg.mispredict_total <= miss_count_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    // Nothing may be in flight while the counter memory is being swept.
    a_idle_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        table_busy |-> (!s1_valid_reg && !result_valid_reg))
        else $error("branch in flight during counter sweep");

    // Every completed lookup bumps the branch total unless it is saturated.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (branch_count_reg != TOTAL_MAX))
            |=> (branch_count_reg == $past(branch_count_reg) + TOTAL_W'(1)))
        else $error("branch total did not advance");

    // A reported misprediction is always counted in the miss total.
    a_miss_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.mispredicted) |-> (result.mispredict_total != '0))
        else $error("misprediction missing from total");
`endif

endmodule

// ===== rtl/gbp_index_hash.sv =====
// gbp_index_hash: clamps the configured widths and forms the gshare index
// and the next global history. Purely combinational; uses gbp_pkg.
`timescale 1ns / 1ps

module gbp_index_hash
    import gbp_pkg::*;
#(
    parameter int IDX_W = 12
)
(
    input  logic [PC_WIDTH-1:0] pc,
    input  logic                taken,
    input  logic [IDX_W-1:0]    history,
    input  logic [CFG_W-1:0]    index_bits,
    input  logic [CFG_W-1:0]    history_bits,
    output logic [IDX_W-1:0]    index,
    output logic [IDX_W-1:0]    history_next
);

    localparam int CW = $clog2(IDX_W + 1);

    logic [CW-1:0]             m;
    logic [CW-1:0]             n;
    logic [IDX_W-1:0]          mmask;
    logic [IDX_W-1:0]          nmask;
    logic [IDX_W-1:0]          hist;
    logic [IDX_W-1:0]          top_bit;
    logic [PC_WIDTH+IDX_W-1:0] pc_ext;
    logic [IDX_W-1:0]          pc_idx;

    // The address is word aligned, so its two low bits are dropped.
    assign pc_ext = {{IDX_W{1'b0}}, pc};
    assign pc_idx = pc_ext[IDX_W+1:2];

    always_comb
    begin
        if (index_bits == '0)
        begin
            m = CW'(1);
        end
        else if (int'(index_bits) > IDX_W)
        begin
            m = CW'(IDX_W);
        end
        else
        begin
            m = CW'(index_bits);
        end

        if (history_bits == '0)
        begin
            n = CW'(1);
        end
        else if (int'(history_bits) > int'(m))
        begin
            n = m;
        end
        else
        begin
            n = CW'(history_bits);
        end

        for (int i = 0; i < IDX_W; i++)
        begin
            mmask[i] = (i < int'(m));
            nmask[i] = (i < int'(n));
        end

        hist         = history & nmask;
        index        = (pc_idx & mmask) ^ hist;
        top_bit      = taken ? (IDX_W'(1) << (n - CW'(1))) : '0;
        history_next = (hist >> 1) | top_bit;
    end

endmodule

// ===== rtl/gbp_counter_table.sv =====
// gbp_counter_table: the counter memory with a clearing sweep after reset,
// a registered read port and a bypass of the latest write. Uses gbp_pkg.
`timescale 1ns / 1ps

module gbp_counter_table
    import gbp_pkg::*;
#(
    parameter int IDX_W = 12
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [CNT_W-1:0] wr_data,
    output logic [CNT_W-1:0] rd_data,
    output logic             busy
);

    localparam int DEPTH = 1 << IDX_W;

    logic [CNT_W-1:0] mem [DEPTH];

    logic             clr_reg;
    logic             clr_next;
    logic [IDX_W-1:0] clr_addr_reg;
    logic [IDX_W-1:0] clr_addr_next;

    logic [IDX_W-1:0] rd_addr_reg;
    logic [CNT_W-1:0] mem_data_reg;

    logic             lw_valid_reg;
    logic [IDX_W-1:0] lw_addr_reg;
    logic [CNT_W-1:0] lw_data_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [CNT_W-1:0] mem_wdata;

    always_comb
    begin
        clr_addr_next = clr_addr_reg + IDX_W'(1);
        clr_next      = clr_reg && (clr_addr_reg != '1);
    end

    assign mem_we    = clr_reg || wr_en;
    assign mem_waddr = clr_reg ? clr_addr_reg : wr_addr;
    assign mem_wdata = clr_reg ? CNT_INIT : wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_reg)
            begin
                clr_reg      <= clr_next;
                clr_addr_reg <= clr_addr_next;
            end
            if (clr_reg)
            begin
                lw_valid_reg <= 1'b0;
            end
            else if (wr_en)
            begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            mem_data_reg <= mem[rd_addr];
            rd_addr_reg  <= rd_addr;
        end
        if (wr_en && !clr_reg)
        begin
            lw_addr_reg <= wr_addr;
            lw_data_reg <= wr_data;
        end
    end

    // A read issued on the same edge as a write to that entry saw old data.
    assign rd_data = (lw_valid_reg && (lw_addr_reg == rd_addr_reg)) ? lw_data_reg
                                                                      : mem_data_reg;
    assign busy    = clr_reg;

endmodule

// ===== verif/gshare_branch_predictor_test.sv =====
// Self-checking testbench for gshare_branch_predictor: directed and random branch
// beats under several table and history settings, checked against a built-in model.
// Depends on gbp_pkg and the gshare_branch_predictor RTL.
`timescale 1ns / 1ps

module gshare_branch_predictor_test;

    import gbp_pkg::*;

    localparam int TABLE_BITS     = 12;
    localparam int TABLE_SIZE     = 1 << TABLE_BITS;
    localparam int PHASE_ITEMS    = 110;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF_AFTER = 250;
    localparam int HOLD_OFF_LEN   = 150;
    localparam int POOL_SIZE      = 16;

    // Register indexes that the block does not decode; writes to them are dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

    // Behavior of one branch address in the random pool.
    typedef enum int {
        BIAS_TAKEN,
        BIAS_NOT_TAKEN,
        BIAS_ALTERNATE,
        BIAS_MOSTLY_TAKEN
    } bias_e;

    // Scoreboard: mirrors the counter table, the history and the totals, and
    // holds the predictions that are still waiting for their result beat.
    class gshare_book;
        logic [CNT_W-1:0] counters [TABLE_SIZE];
        int unsigned      history;
        logic [TOTAL_W-1:0] branch_total;
        logic [TOTAL_W-1:0] miss_total;
        logic [CFG_W-1:0] index_bits;
        logic [CFG_W-1:0] history_bits;
        result_t          expected_q[$];
        int               errors;

        function new();
            foreach (counters[i])
                counters[i] = CNT_INIT;
            history      = 0;
            branch_total = '0;
            miss_total   = '0;
            index_bits   = RST_INDEX_BITS;
            history_bits = RST_HISTORY_BITS;
            errors       = 0;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_INDEX_BITS:   index_bits = val;
                CFG_HISTORY_BITS: history_bits = val;
                default:          ;
            endcase
        endfunction

        function void note_branch(branch_t b);
            int unsigned m;
            int unsigned n;
            int unsigned word;
            int unsigned hist;
            logic [TABLE_BITS-1:0] slot;
            logic [CNT_W-1:0] level;
            result_t exp_r;
            // Out-of-range widths are clamped, and the history never outgrows the index.
            m = 32'(index_bits);
            if (m < 1) m = 1;
            if (m > TABLE_BITS) m = TABLE_BITS;
            n = 32'(history_bits);
            if (n < 1) n = 1;
            if (n > m) n = m;
            word = 32'(b.branch_pc) >> 2;
            hist = history & ((32'd1 << n) - 1);
            slot = TABLE_BITS'((word & ((32'd1 << m) - 1)) ^ hist);
            level = counters[slot];
            exp_r.predicted_taken = (level >= CNT_INIT);
            exp_r.mispredicted    = (b.taken != exp_r.predicted_taken);
            if (b.taken && level != CNT_MAX)
                counters[slot] = level + CNT_W'(1);
            else if (!b.taken && level != CNT_MIN)
                counters[slot] = level - CNT_W'(1);
            // Only the low n history bits survive the shift.
            hist = hist >> 1;
            if (b.taken)
                hist = hist | (32'd1 << (n - 1));
            history = hist;
            if (branch_total != TOTAL_MAX)
                branch_total = branch_total + TOTAL_W'(1);
            if (exp_r.mispredicted && miss_total != TOTAL_MAX)
                miss_total = miss_total + TOTAL_W'(1);
            exp_r.prediction_total = branch_total;
            exp_r.mispredict_total = miss_total;
            expected_q.push_back(exp_r);
        endfunction

        function void check_result(result_t r);
            result_t exp_r;
            if (expected_q.size() == 0) begin
                $error("result beat with no prediction waiting");
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (r.predicted_taken !== exp_r.predicted_taken) begin
                $error("predicted_taken: expected %0d, got %0d",
                       exp_r.predicted_taken, r.predicted_taken);
                errors++;
            end
            if (r.mispredicted !== exp_r.mispredicted) begin
                $error("mispredicted: expected %0d, got %0d",
                       exp_r.mispredicted, r.mispredicted);
                errors++;
            end
            if (r.prediction_total !== exp_r.prediction_total) begin
                $error("prediction_total: expected %0d, got %0d",
                       exp_r.prediction_total, r.prediction_total);
                errors++;
            end
            if (r.mispredict_total !== exp_r.mispredict_total) begin
                $error("mispredict_total: expected %0d, got %0d",
                       exp_r.mispredict_total, r.mispredict_total);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 branch_valid = 1'b0;
    logic                 branch_ready;
    branch_t              branch       = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_t              result;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;

    gshare_book book;
    int         burst_left  = 0;
    bit         steady      = 1'b0;
    int         idle_cycles = 0;

    always #4 clk = ~clk;

    gshare_branch_predictor #(
        .MAX_INDEX_BITS(TABLE_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .branch_valid (branch_valid),
        .branch_ready (branch_ready),
        .branch       (branch),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Offers one branch beat and returns at the edge that accepts it. The sender
    // works in bursts; a gap drops valid only between beats, never under one.
    task automatic send_branch(input logic [PC_WIDTH-1:0] pc, input logic taken);
        int gap;
        branch_t b;
        b.branch_pc = pc;
        b.taken     = taken;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                branch_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        branch_valid <= 1'b1;
        branch       <= b;
        do @(posedge clk); while (!branch_ready);
        book.note_branch(b);
    endtask

    // Waits for the block to go idle, then writes both registers back to back,
    // optionally preceded by writes to the undecoded indexes.
    task automatic apply_setting(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] n,
                                 input bit with_stray);
        logic [CFG_IDX_W-1:0] idx_list [4];
        logic [CFG_W-1:0]     val_list [4];
        int count;
        count = 0;
        if (with_stray) begin
            idx_list[0] = CFG_UNUSED_LO;
            val_list[0] = CFG_W'($urandom_range(0, 15));
            idx_list[1] = CFG_UNUSED_HI;
            val_list[1] = CFG_W'($urandom_range(0, 15));
            count = 2;
        end
        idx_list[count]     = CFG_INDEX_BITS;
        val_list[count]     = m;
        idx_list[count + 1] = CFG_HISTORY_BITS;
        val_list[count + 1] = n;
        count = count + 2;
        while (book.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        for (int i = 0; i < count; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= val_list[i];
            do @(posedge clk); while (!cfg_ready);
            book.note_config(idx_list[i], val_list[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random branches: mostly a small pool of recurring addresses with their own
    // direction habits, so counters saturate and history correlations matter,
    // plus some fully random addresses and outcomes.
    task automatic run_phase(input int items);
        logic [PC_WIDTH-1:0] pool_pc   [POOL_SIZE];
        bias_e               pool_bias [POOL_SIZE];
        logic                pool_last [POOL_SIZE];
        int                  pick;
        logic [PC_WIDTH-1:0] pc;
        logic                taken;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_pc[i]   = PC_WIDTH'($urandom_range(0, (1 << PC_WIDTH) - 1));
            pool_bias[i] = bias_e'($urandom_range(0, 3));
            pool_last[i] = 1'b0;
        end
        for (int k = 0; k < items; k++) begin
            if ($urandom_range(0, 99) < 15) begin
                pc    = PC_WIDTH'($urandom_range(0, (1 << PC_WIDTH) - 1));
                taken = 1'($urandom_range(0, 1));
            end else begin
                pick = $urandom_range(0, POOL_SIZE - 1);
                pc   = pool_pc[pick];
                case (pool_bias[pick])
                    BIAS_TAKEN:        taken = 1'b1;
                    BIAS_NOT_TAKEN:    taken = 1'b0;
                    BIAS_ALTERNATE:    taken = ~pool_last[pick];
                    BIAS_MOSTLY_TAKEN: taken = ($urandom_range(0, 3) != 0);
                    default:           taken = 1'b0;
                endcase
                pool_last[pick] = taken;
            end
            send_branch(pc, taken);
        end
        branch_valid <= 1'b0;
    endtask

    // Result side: random short stalls, and once a long hold-off while the sender
    // keeps offering beats, so the pipeline fills and branch_ready drops.
    initial begin : result_sink
        int  stall_left;
        int  seen;
        bit  held_off;
        stall_left = 0;
        seen       = 0;
        held_off   = 1'b0;
        forever begin
            @(posedge clk);
            if (result_valid && result_ready) begin
                book.check_result(result);
                seen++;
            end
            if (!held_off && seen >= HOLD_OFF_AFTER) begin
                held_off   = 1'b1;
                stall_left = HOLD_OFF_LEN;
            end else if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 6);
            end
            if (stall_left > 0) begin
                result_ready <= 1'b0;
                stall_left--;
            end else begin
                result_ready <= 1'b1;
            end
        end
    end

    // Watchdog: the reset sweep of the counter memory and the long hold-off are
    // the longest stretches without a beat, both far below the limit.
    always @(posedge clk) begin
        if ((branch_valid && branch_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] set_m [8];
        logic [CFG_W-1:0] set_n [8];
        book = new();
        // Extremes of both registers, clamping of each, and history longer than index.
        set_m = '{4'd0, 4'd15, 4'd12, 4'd1, 4'd4, 4'd13, 4'd9, 4'd7};
        set_n = '{4'd0, 4'd15, 4'd12, 4'd1, 4'd15, 4'd1, 4'd3, 4'd5};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset setting: one address driven to the taken
        // ceiling, then back down to the not-taken floor, then the address extremes.
        repeat (8) send_branch(24'h000000, 1'b1);
        repeat (10) send_branch(24'h000000, 1'b0);
        send_branch(24'hFFFFFF, 1'b1);
        send_branch(24'hFFFFFF, 1'b0);
        send_branch(24'hFFFFFC, 1'b1);
        send_branch(24'h000003, 1'b0);
        send_branch(24'hAAAAAA, 1'b1);
        send_branch(24'h555555, 1'b0);
        branch_valid <= 1'b0;

        // Settings change only between phases; the table, history and totals carry
        // over, so a shorter history also drops the upper history bits.
        for (int p = 0; p < 8; p++) begin
            apply_setting(set_m[p], set_n[p], (p == 0 || p == 5));
            steady = (p == 3);
            run_phase(PHASE_ITEMS);
        end
        steady = 1'b0;

        while (book.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES * 2) @(posedge clk);
        if (book.pending() != 0) begin
            $error("%0d predictions never got a result beat", book.pending());
            book.errors++;
        end
        if (book.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
